@@ sv/sobel_edge_magnitude_3x3_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - assertion macros
// Clocked implication checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - package
// Shared widths, register reset values and the pipeline control types.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = 12;
    localparam int GRAD_W = 10;
    localparam int SUM_W  = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;
    localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_PIX,
        KIND_TAIL,
        KIND_DRAIN
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  emit;
        logic  first_col;
        logic  last_col;
        logic  interior;
        logic  frame_last;
    } t_s1_ctl;

endpackage

@@ sv/sem_cfg.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - configuration registers
// APB frame width and height, clamped frame geometry and frame restart.
// ----------------------------------------------------------------------------
module sem_cfg #(
    parameter int MAX_LINE = 2048,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sem_pkg::APB_AW-1:0]     paddr,
    input  logic [sem_pkg::APB_DW-1:0]     pwdata,
    output logic [sem_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    output logic [COL_W-1:0]               o_w_last,
    output logic [sem_pkg::ROW_W-1:0]      o_h_eff,
    output logic                           o_restart
);

    logic [sem_pkg::CFG_W-1:0] r_frame_width;
    logic [sem_pkg::CFG_W-1:0] r_frame_height;
    logic                      wr_stb;
    sem_pkg::t_reg_idx         reg_idx;

    assign pready    = 1'b1;
    assign wr_stb    = psel & penable & pwrite & pready;
    assign reg_idx   = sem_pkg::t_reg_idx'(paddr[sem_pkg::APB_AW-1]);
    assign o_restart = wr_stb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::WIDTH_RESET;
            r_frame_height <= sem_pkg::HEIGHT_RESET;
        end else if (wr_stb) begin
            case (reg_idx)
                sem_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[sem_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sem_pkg::REG_FRAME_WIDTH:
                prdata = {{(sem_pkg::APB_DW-sem_pkg::CFG_W){1'b0}}, r_frame_width};
            sem_pkg::REG_FRAME_HEIGHT:
                prdata = {{(sem_pkg::APB_DW-sem_pkg::CFG_W){1'b0}}, r_frame_height};
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_width < sem_pkg::DIM_MIN) begin
            o_w_last = COL_W'(2);
        end else if (32'(r_frame_width) > MAX_LINE) begin
            o_w_last = COL_W'(MAX_LINE - 1);
        end else begin
            o_w_last = COL_W'(r_frame_width - 12'd1);
        end
    end

    assign o_h_eff = (r_frame_height < sem_pkg::DIM_MIN) ? sem_pkg::DIM_MIN : r_frame_height;

endmodule

@@ sv/sem_scan.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - raster scan and line store read stage
// Tracks column and row, classifies each item and issues the line store read.
// ----------------------------------------------------------------------------
module sem_scan #(
    parameter int MAX_LINE = 2048,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sem_pkg::PIX_W-1:0]     i_gray_in,
    input  logic                          i_drain,
    input  logic [COL_W-1:0]              i_w_last,
    input  logic [sem_pkg::ROW_W-1:0]     i_h_eff,
    input  logic                          i_restart,
    input  logic                          i_s2_free,
    output logic                          o_s1_valid,
    output sem_pkg::t_s1_ctl              o_s1_ctl,
    output logic [sem_pkg::PIX_W-1:0]     o_s1_pix,
    output logic [COL_W-1:0]              o_s1_addr,
    output logic                          o_rd_en,
    output logic [COL_W-1:0]              o_rd_addr
);

    logic [COL_W-1:0]              r_col;
    logic [sem_pkg::ROW_W-1:0]     r_row;
    logic                          r_dtail;
    logic                          r_s1_valid;
    sem_pkg::t_s1_ctl              r_s1_ctl;
    logic [sem_pkg::PIX_W-1:0]     r_s1_pix;
    logic [COL_W-1:0]              r_s1_addr;

    logic [COL_W-1:0]              n_col;
    logic [sem_pkg::ROW_W-1:0]     n_row;
    logic                          n_dtail;
    sem_pkg::t_s1_ctl              n_ctl;
    logic                          enter;
    logic                          rd_req;
    logic                          accept;
    logic                          pix_phase;
    logic                          first_col;
    logic                          last_col;

    assign o_ready   = !r_s1_valid | i_s2_free;
    assign accept    = i_valid & o_ready;
    assign pix_phase = r_row < i_h_eff;
    assign first_col = (r_col == '0);
    assign last_col  = (r_col == i_w_last);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_dtail = r_dtail;
        n_ctl   = '0;
        enter   = 1'b0;
        rd_req  = 1'b0;
        if (pix_phase) begin
            if (!i_drain) begin
                enter           = 1'b1;
                rd_req          = 1'b1;
                n_ctl.kind      = sem_pkg::KIND_PIX;
                n_ctl.first_col = first_col;
                n_ctl.last_col  = last_col;
                n_ctl.emit      = !(r_row == '0) && !((r_row == sem_pkg::ROW_W'(1)) && first_col);
                n_ctl.interior  = (r_col >= COL_W'(2)) && (r_row >= sem_pkg::ROW_W'(2));
                if (last_col) begin
                    n_col = '0;
                    n_row = r_row + sem_pkg::ROW_W'(1);
                    if (r_row + sem_pkg::ROW_W'(1) == i_h_eff) begin
                        n_dtail = 1'b1;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end else if (r_dtail) begin
            enter      = 1'b1;
            n_ctl.kind = sem_pkg::KIND_TAIL;
            n_dtail    = 1'b0;
        end else begin
            enter            = 1'b1;
            rd_req           = 1'b1;
            n_ctl.kind       = sem_pkg::KIND_DRAIN;
            n_ctl.frame_last = last_col;
            if (last_col) begin
                n_col = '0;
                n_row = '0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_dtail    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_col   <= '0;
                r_row   <= '0;
                r_dtail <= 1'b0;
            end else if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_dtail <= n_dtail;
            end
            if (o_ready) begin
                r_s1_valid <= accept & enter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept & enter) begin
            r_s1_ctl  <= n_ctl;
            r_s1_pix  <= i_gray_in;
            r_s1_addr <= r_col;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_pix   = r_s1_pix;
    assign o_s1_addr  = r_s1_addr;
    assign o_rd_en    = accept & rd_req;
    assign o_rd_addr  = r_col;

endmodule

@@ sv/sem_line_mem.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - line store memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sem_line_mem #(
    parameter int DEPTH = 2048,
    parameter int DATA_W = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/sem_filt.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - window and gradient pipeline
// Writes the line stores back, shifts the 3x3 window, forms |gx| and |gy|,
// then sums, saturates and holds the result item for the output side.
// ----------------------------------------------------------------------------
module sem_filt #(
    parameter int MAX_LINE = 2048,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s1_valid,
    input  sem_pkg::t_s1_ctl                i_s1_ctl,
    input  logic [sem_pkg::PIX_W-1:0]       i_s1_pix,
    input  logic [COL_W-1:0]                i_s1_addr,
    input  logic [2*sem_pkg::PIX_W-1:0]     i_rd_data,
    output logic                            o_s2_free,
    output logic                            o_wr_en,
    output logic [COL_W-1:0]                o_wr_addr,
    output logic [2*sem_pkg::PIX_W-1:0]     o_wr_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sem_pkg::PIX_W-1:0]       o_edge_value,
    output logic                            o_on_border,
    output logic                            o_frame_last
);

    logic [sem_pkg::PIX_W-1:0]  r_win [3][3];
    logic [sem_pkg::PIX_W-1:0]  r_tail;

    logic                       r_s2_valid;
    logic                       r_s2_border;
    logic                       r_s2_last;
    logic [sem_pkg::PIX_W-1:0]  r_s2_value;

    logic                       r_s3_valid;
    logic                       r_s3_border;
    logic                       r_s3_last;
    logic [sem_pkg::PIX_W-1:0]  r_s3_value;
    logic [sem_pkg::GRAD_W-1:0] r_s3_gx_abs;
    logic [sem_pkg::GRAD_W-1:0] r_s3_gy_abs;

    logic                       r_out_valid;
    logic [sem_pkg::PIX_W-1:0]  r_out_value;
    logic                       r_out_border;
    logic                       r_out_last;

    logic                       n_s2_valid;
    logic                       n_s2_border;
    logic                       n_s2_last;
    logic [sem_pkg::PIX_W-1:0]  n_s2_value;

    logic                       out_free;
    logic                       s3_free;
    logic                       s3_go;
    logic                       s2_free;
    logic                       s2_go;
    logic                       s1_go;
    logic                       is_pix;
    logic [sem_pkg::PIX_W-1:0]  top;
    logic [sem_pkg::PIX_W-1:0]  mid;
    logic [sem_pkg::GRAD_W-1:0] gx_pos;
    logic [sem_pkg::GRAD_W-1:0] gx_neg;
    logic [sem_pkg::GRAD_W-1:0] gy_pos;
    logic [sem_pkg::GRAD_W-1:0] gy_neg;
    logic [sem_pkg::GRAD_W-1:0] gx_abs;
    logic [sem_pkg::GRAD_W-1:0] gy_abs;
    logic [sem_pkg::SUM_W-1:0]  mag_sum;
    logic [sem_pkg::PIX_W-1:0]  mag_sat;

    assign out_free  = !r_out_valid | i_ready;
    assign s3_free   = !r_s3_valid | out_free;
    assign s3_go     = r_s3_valid & out_free;
    assign s2_free   = !r_s2_valid | s3_free;
    assign s2_go     = r_s2_valid & s3_free;
    assign s1_go     = i_s1_valid & s2_free;
    assign o_s2_free = s2_free;

    assign is_pix = (i_s1_ctl.kind == sem_pkg::KIND_PIX);
    assign top    = i_rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
    assign mid    = i_rd_data[sem_pkg::PIX_W-1:0];

    // line store word: previous-previous line above, previous line below
    assign o_wr_en   = s1_go & is_pix;
    assign o_wr_addr = i_s1_addr;
    assign o_wr_data = {mid, i_s1_pix};

    always_comb begin
        n_s2_valid  = 1'b1;
        n_s2_border = 1'b1;
        n_s2_last   = 1'b0;
        n_s2_value  = r_tail;
        case (i_s1_ctl.kind)
            sem_pkg::KIND_PIX: begin
                n_s2_valid  = i_s1_ctl.emit;
                n_s2_border = !i_s1_ctl.interior;
                n_s2_value  = i_s1_ctl.first_col ? r_tail : r_win[1][2];
            end
            sem_pkg::KIND_TAIL: begin
                n_s2_value = r_tail;
            end
            sem_pkg::KIND_DRAIN: begin
                n_s2_value = mid;
                n_s2_last  = i_s1_ctl.frame_last;
            end
            default: begin
                n_s2_valid = 1'b0;
            end
        endcase
    end

    // advance window one column
    always_ff @(posedge i_clk) begin
        if (s1_go & is_pix) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= top;
            r_win[1][2] <= mid;
            r_win[2][2] <= i_s1_pix;
            if (i_s1_ctl.last_col) begin
                r_tail <= mid;
            end
        end
    end

    assign gx_pos = sem_pkg::GRAD_W'(r_win[0][2]) + sem_pkg::GRAD_W'({r_win[1][2], 1'b0})
                  + sem_pkg::GRAD_W'(r_win[2][2]);
    assign gx_neg = sem_pkg::GRAD_W'(r_win[0][0]) + sem_pkg::GRAD_W'({r_win[1][0], 1'b0})
                  + sem_pkg::GRAD_W'(r_win[2][0]);
    assign gy_pos = sem_pkg::GRAD_W'(r_win[2][0]) + sem_pkg::GRAD_W'({r_win[2][1], 1'b0})
                  + sem_pkg::GRAD_W'(r_win[2][2]);
    assign gy_neg = sem_pkg::GRAD_W'(r_win[0][0]) + sem_pkg::GRAD_W'({r_win[0][1], 1'b0})
                  + sem_pkg::GRAD_W'(r_win[0][2]);
    assign gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
    assign gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);

    assign mag_sum = sem_pkg::SUM_W'(r_s3_gx_abs) + sem_pkg::SUM_W'(r_s3_gy_abs);
    assign mag_sat = (mag_sum > sem_pkg::SUM_W'(sem_pkg::PIX_MAX)) ? sem_pkg::PIX_MAX
                   : mag_sum[sem_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= s1_go & n_s2_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_border <= n_s2_border;
            r_s2_last   <= n_s2_last;
            r_s2_value  <= n_s2_value;
        end
        if (s2_go) begin
            r_s3_border <= r_s2_border;
            r_s3_last   <= r_s2_last;
            r_s3_value  <= r_s2_value;
            r_s3_gx_abs <= gx_abs;
            r_s3_gy_abs <= gy_abs;
        end
        if (s3_go) begin
            r_out_border <= r_s3_border;
            r_out_last   <= r_s3_last;
            r_out_value  <= r_s3_border ? r_s3_value : mag_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_out_value;
    assign o_on_border  = r_out_border;
    assign o_frame_last = r_out_last;

endmodule

@@ sv/sobel_edge_magnitude_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - 3x3 L1 gradient magnitude on a gray pixel stream
// Each result is registered through the read, s2, s3 and output stages.
// Throughput: one item per cycle; four registered stages hold items under stall.
// Reset clears control state and restores 640 x 480; line stores are not cleared.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_3x3_unit_assert.svh"

module sobel_edge_magnitude_3x3_unit #(
    parameter int MAX_LINE = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sem_pkg::APB_AW-1:0]    paddr,
    input  logic [sem_pkg::APB_DW-1:0]    pwdata,
    output logic [sem_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sem_pkg::PIX_W-1:0]     i_gray_in,
    input  logic                          i_drain,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sem_pkg::PIX_W-1:0]     o_edge_value,
    output logic                          o_on_border,
    output logic                          o_frame_last
);

    localparam int COL_W = $clog2(MAX_LINE);

    logic [COL_W-1:0]                w_last;
    logic [sem_pkg::ROW_W-1:0]       h_eff;
    logic                            restart;
    logic                            s2_free;
    logic                            s1_valid;
    sem_pkg::t_s1_ctl                s1_ctl;
    logic [sem_pkg::PIX_W-1:0]       s1_pix;
    logic [COL_W-1:0]                s1_addr;
    logic                            rd_en;
    logic [COL_W-1:0]                rd_addr;
    logic [2*sem_pkg::PIX_W-1:0]     rd_data;
    logic                            wr_en;
    logic [COL_W-1:0]                wr_addr;
    logic [2*sem_pkg::PIX_W-1:0]     wr_data;

    sem_cfg #(
        .MAX_LINE (MAX_LINE)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_w_last  (w_last),
        .o_h_eff   (h_eff),
        .o_restart (restart)
    );

    sem_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_gray_in  (i_gray_in),
        .i_drain    (i_drain),
        .i_w_last   (w_last),
        .i_h_eff    (h_eff),
        .i_restart  (restart),
        .i_s2_free  (s2_free),
        .o_s1_valid (s1_valid),
        .o_s1_ctl   (s1_ctl),
        .o_s1_pix   (s1_pix),
        .o_s1_addr  (s1_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    sem_line_mem #(
        .DEPTH  (MAX_LINE),
        .DATA_W (2*sem_pkg::PIX_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sem_filt #(
        .MAX_LINE (MAX_LINE)
    ) u_filt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1_ctl     (s1_ctl),
        .i_s1_pix     (s1_pix),
        .i_s1_addr    (s1_addr),
        .i_rd_data    (rd_data),
        .o_s2_free    (s2_free),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_value (o_edge_value),
        .o_on_border  (o_on_border),
        .o_frame_last (o_frame_last)
    );

    `SEM_ASSERT_IMPLY(a_mem_no_collide, i_clk, i_rst_n, rd_en && wr_en, rd_addr != wr_addr, "line store read and write hit one entry")
    `SEM_ASSERT_NEXT(a_read_lands, i_clk, i_rst_n, rd_en, s1_valid, "line store read issued without an item in the read stage")
    `SEM_ASSERT_IMPLY(a_last_on_border, i_clk, i_rst_n, o_valid && o_frame_last, o_on_border, "frame end item not flagged as border")
    `SEM_ASSERT_IMPLY(a_stall_from_output, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input stalled while output side is free")

endmodule

@@ tb/sobel_edge_magnitude_3x3_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - self-checking testbench
// Streams gray frames through the unit under random valid/ready gaps, predicts
// every saturated |gx|+|gy| or border pass-through result in a local model and
// compares each result item field by field. Covers the reset frame size, size
// clamping, mid-frame drains, pixels discarded while draining, register restarts
// and the first pixels of the widest and tallest frames.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_unit_test;

    localparam int MAX_LINE      = 2048;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        PAT_NOISE,
        PAT_BINARY,
        PAT_SMOOTH,
        PAT_STRIPES
    } t_pattern;

    typedef struct packed {
        logic [sem_pkg::PIX_W-1:0] edge_value;
        logic                      on_border;
        logic                      frame_last;
    } t_edge_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [sem_pkg::APB_AW-1:0] paddr = '0;
    logic [sem_pkg::APB_DW-1:0] pwdata = '0;
    logic [sem_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [sem_pkg::PIX_W-1:0]  i_gray_in = '0;
    logic                       i_drain = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [sem_pkg::PIX_W-1:0]  o_edge_value;
    logic                       o_on_border;
    logic                       o_frame_last;

    logic [sem_pkg::PIX_W-1:0] line_above [MAX_LINE];
    logic [sem_pkg::PIX_W-1:0] line_prev [MAX_LINE];
    logic [sem_pkg::PIX_W-1:0] win [3][3];
    int unsigned               in_col;
    int unsigned               in_row;
    int unsigned               out_idx;
    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;

    t_edge_result expected_edges [$];
    t_edge_result head_edge;

    int unsigned cyc_cnt = 0;
    int          src_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          n_fail = 0;
    int          n_items = 0;
    int          n_live = 0;
    int          n_results = 0;
    int          n_frames = 0;
    int          n_writes = 0;

    sobel_edge_magnitude_3x3_unit #(
        .MAX_LINE(MAX_LINE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_gray_in   (i_gray_in),
        .i_drain     (i_drain),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_edge_value(o_edge_value),
        .o_on_border (o_on_border),
        .o_frame_last(o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("sobel_edge_magnitude_3x3_unit: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= !(rcv_idle_pct != 0 && cyc_cnt[7:5] != 3'd3
                     && $urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_edges.size() == 0) begin
                $error("result item with no expected item: edge_value %0d", o_edge_value);
                n_fail++;
            end else begin
                head_edge = expected_edges.pop_front();
                if (o_edge_value !== head_edge.edge_value) begin
                    $error("edge_value: expected %0d, actual %0d",
                           head_edge.edge_value, o_edge_value);
                    n_fail++;
                end
                if (o_on_border !== head_edge.on_border) begin
                    $error("on_border: expected %0d, actual %0d",
                           head_edge.on_border, o_on_border);
                    n_fail++;
                end
                if (o_frame_last !== head_edge.frame_last) begin
                    $error("frame_last: expected %0d, actual %0d",
                           head_edge.frame_last, o_frame_last);
                    n_fail++;
                end
            end
        end
    end

    function automatic int unsigned frame_w();
        if (width_reg < sem_pkg::DIM_MIN) return 32'(sem_pkg::DIM_MIN);
        if (width_reg > MAX_LINE) return MAX_LINE;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned frame_h();
        return (height_reg < sem_pkg::DIM_MIN) ? 32'(sem_pkg::DIM_MIN) : 32'(height_reg);
    endfunction

    function automatic void clear_frame_pos();
        in_col  = 0;
        in_row  = 0;
        out_idx = 0;
    endfunction

    function automatic bit predict_edge(input logic [sem_pkg::PIX_W-1:0] gray,
                                        input logic drain, output t_edge_result res);
        int unsigned               w, h, total, c, r, ex, ey;
        int                        gx, gy, mag, i;
        logic [sem_pkg::PIX_W-1:0] val;
        logic                      brd, last;
        w     = frame_w();
        h     = frame_h();
        total = w * h;
        val   = '0;
        brd   = 1'b1;
        last  = 1'b0;
        res   = '0;
        if (in_row < h) begin
            if (drain) return 1'b0;
            c = in_col;
            r = in_row;
            for (i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = line_above[c];
            win[1][2] = line_prev[c];
            win[2][2] = gray;
            if (c == 0 && r >= 2) val = line_above[w-1];
            line_above[c] = line_prev[c];
            line_prev[c]  = gray;
            in_col = c + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row = r + 1;
            end
            if (r < 1 || (r == 1 && c == 0)) return 1'b0;
            if (c >= 1) begin
                if (c >= 2 && r >= 2) begin
                    gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
                       - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
                    gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
                       - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
                    if (gx < 0) gx = -gx;
                    if (gy < 0) gy = -gy;
                    mag = gx + gy;
                    val = (mag > int'(sem_pkg::PIX_MAX)) ? sem_pkg::PIX_MAX
                                                          : mag[sem_pkg::PIX_W-1:0];
                    brd = 1'b0;
                end else begin
                    val = win[1][1];
                end
            end
        end else begin
            if (out_idx >= total) begin
                clear_frame_pos();
                return 1'b0;
            end
            ex  = out_idx % w;
            ey  = out_idx / w;
            val = (ey >= h - 1) ? line_prev[ex] : line_above[ex];
        end
        if (out_idx == total - 1) begin
            last = 1'b1;
            clear_frame_pos();
        end else begin
            out_idx = (out_idx + 1) & 32'h007F_FFFF;
        end
        res.edge_value = val;
        res.on_border  = brd;
        res.frame_last = last;
        return 1'b1;
    endfunction

    function automatic logic [sem_pkg::PIX_W-1:0] pick_pixel(input t_pattern pat,
                                                             input int unsigned r,
                                                             input int unsigned c,
                                                             input int unsigned base);
        case (pat)
            PAT_NOISE:  return sem_pkg::PIX_W'($urandom);
            PAT_BINARY: return $urandom_range(1) ? sem_pkg::PIX_MAX : '0;
            PAT_SMOOTH: return sem_pkg::PIX_W'(base + r + c + $urandom_range(3));
            default:    return (c % 2) ? sem_pkg::PIX_MAX : '0;
        endcase
    endfunction

    task automatic send_item(input logic [sem_pkg::PIX_W-1:0] gray, input logic drain);
        t_edge_result res;
        bit           ignored;
        @(negedge i_clk);
        while (src_idle_pct != 0 && cyc_cnt[8:6] != 3'd0
               && $urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_gray_in <= gray;
        i_drain   <= drain;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ignored = drain && (in_row < frame_h());
        if (predict_edge(gray, drain, res)) expected_edges.push_back(res);
        n_items++;
        if (!ignored) n_live++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input sem_pkg::t_reg_idx idx,
                             input logic [sem_pkg::CFG_W-1:0] value);
        logic [sem_pkg::APB_DW-1:0] data;
        data = $urandom;
        data[sem_pkg::CFG_W-1:0] = value;
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {(sem_pkg::APB_AW-1){1'b0}}};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready !== 1'b1) begin
            $error("pready: expected 1, actual %0b", pready);
            n_fail++;
        end
        if (idx == sem_pkg::REG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        clear_frame_pos();
        n_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[sem_pkg::CFG_W-1:0] !== value) begin
            $error("prdata: expected %0d, actual %0d", value, prdata[sem_pkg::CFG_W-1:0]);
            n_fail++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // cut != 0: stop after that many pixels and skip the tail
    task automatic send_frame(input t_pattern pat, input int drain_pct, input int discard_pct,
                              input int unsigned cut, input bit hold_mid);
        int unsigned w, h, r, c, k, base, sent;
        w    = frame_w();
        h    = frame_h();
        base = $urandom_range(255);
        sent = 0;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                if (cut != 0 && sent == cut) return;
                if (hold_mid && sent == (w * h) / 2) wait_drained();
                if (drain_pct != 0 && $urandom_range(99) < drain_pct)
                    send_item(sem_pkg::PIX_W'($urandom), 1'b1);
                send_item(pick_pixel(pat, r, c, base), 1'b0);
                sent++;
            end
        end
        for (k = 0; k <= w; k++)
            send_item(sem_pkg::PIX_W'($urandom), $urandom_range(99) >= discard_pct);
        n_frames++;
    endtask

    task automatic test_reset_size();
        int i;
        for (i = 0; i < 645; i++) send_item(sem_pkg::PIX_W'($urandom), 1'b0);
    endtask

    task automatic test_directed();
        logic [sem_pkg::PIX_W-1:0] step_frame [9];
        logic [sem_pkg::PIX_W-1:0] faint_frame [9];
        int i;
        step_frame  = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
        faint_frame = '{8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
        write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd0);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd2);
        for (i = 0; i < 9; i++) begin
            send_item(step_frame[i], 1'b0);
            if (i == 3) send_item(8'hFF, 1'b1);
        end
        send_item(8'h00, 1'b1);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'hFF, 1'b1);
        for (i = 0; i < 9; i++) send_item(faint_frame[i], 1'b0);
        repeat (4) send_item(8'h00, 1'b1);
        n_frames += 2;
    endtask

    task automatic test_register_restart();
        int i;
        write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd6);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd4);
        for (i = 0; i < 9; i++) send_item(sem_pkg::PIX_W'($urandom), 1'b0);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd5);
        send_frame(PAT_NOISE, 0, 0, 0, 1'b0);
        write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd1);
        send_frame(PAT_STRIPES, 0, 0, 0, 1'b0);
    endtask

    task automatic test_widest_frame();
        write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd4095);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd3);
        send_frame(PAT_NOISE, 0, 10, 40, 1'b0);
    endtask

    task automatic test_tallest_frame();
        write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd4095);
        send_frame(PAT_BINARY, 0, 10, 45, 1'b0);
    endtask

    task automatic test_random_frames(input int count);
        int          start;
        bit          first;
        int unsigned cut;
        t_pattern    pat;
        start = n_live;
        first = 1'b1;
        while (n_live - start < count) begin
            if (first || in_row != 0 || in_col != 0 || $urandom_range(2) == 0) begin
                if ($urandom_range(4) == 0)
                    write_reg(sem_pkg::REG_FRAME_WIDTH, sem_pkg::CFG_W'($urandom_range(2)));
                else
                    write_reg(sem_pkg::REG_FRAME_WIDTH,
                              sem_pkg::CFG_W'($urandom_range(10, 3)));
                if (first || $urandom_range(1)) begin
                    if ($urandom_range(4) == 0)
                        write_reg(sem_pkg::REG_FRAME_HEIGHT,
                                  sem_pkg::CFG_W'($urandom_range(2)));
                    else
                        write_reg(sem_pkg::REG_FRAME_HEIGHT,
                                  sem_pkg::CFG_W'($urandom_range(6, 3)));
                end
            end
            pat = t_pattern'($urandom_range(3));
            cut = ($urandom_range(9) == 0) ? $urandom_range(frame_w() * frame_h(), 1) : 0;
            send_frame(pat, 8, 25, cut, first || $urandom_range(7) == 0);
            first = 1'b0;
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < MAX_LINE; k++) begin
            line_above[k] = '0;
            line_prev[k]  = '0;
        end
        win        = '{default: '0};
        width_reg  = sem_pkg::WIDTH_RESET;
        height_reg = sem_pkg::HEIGHT_RESET;
        clear_frame_pos();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 16;
        rcv_idle_pct = 77;
        test_reset_size();
        test_directed();
        test_register_restart();
        test_random_frames(20);

        src_idle_pct = 77;
        rcv_idle_pct = 16;
        test_widest_frame();
        test_random_frames(20);

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        test_tallest_frame();
        test_random_frames(20);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("ran %0d items (%0d not ignored), checked %0d results over %0d frames",
                 n_items, n_live, n_results, n_frames);
        $display("made %0d register writes, clamped sizes and the first lines of a %0s",
                 n_writes, "2048-wide and a 4095-tall frame");
        if (n_fail == 0 && expected_edges.size() == 0) begin
            $display("sobel_edge_magnitude_3x3_unit: match");
        end else begin
            $display("sobel_edge_magnitude_3x3_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ sobel_edge_magnitude_3x3_unit.f @@
+incdir+sv
sv/sem_pkg.sv
sv/sem_cfg.sv
sv/sem_scan.sv
sv/sem_line_mem.sv
sv/sem_filt.sv
sv/sobel_edge_magnitude_3x3_unit.sv
tb/sobel_edge_magnitude_3x3_unit_test.sv
